@@ hw/rtl/tpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tpcs_pkg
// Shared widths and types of the two-point code scaler.
// ----------------------------------------------------------------------------
package tpcs_pkg;

  // SCALE is 2^47 / VALUE_MAX; it fits 48 bits for any VALUE_MAX >= 1
  localparam int SCALE_SHIFT = 64 - 16 - 1;
  localparam int SCALE_W     = SCALE_SHIFT + 1;
  localparam int SLOPE_W     = 64;
  localparam int WORD_W      = 16;
  localparam int NUM_W       = 82;
  localparam int QUO_W       = 16;

  // Calibration register indexes
  localparam logic [1:0] REG_P1_VALUE = 2'd0;
  localparam logic [1:0] REG_P1_CODE  = 2'd1;
  localparam logic [1:0] REG_P2_VALUE = 2'd2;
  localparam logic [1:0] REG_P2_CODE  = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  // Coefficients formed from the calibration points
  typedef struct packed {
    logic               dc_zero;
    logic               slope_zero;
    logic [SLOPE_W-1:0] slope;
    logic [NUM_W-1:0]   add0;   // SCALE/2 - offset
    logic [NUM_W-1:0]   add1;   // offset + slope/2
  } coef_t;

  // One divider stage
  typedef struct packed {
    logic               valid;
    logic               fault;
    logic               zero;
    logic               clamp;
    logic [SLOPE_W-1:0] div;
    logic [NUM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
    word_t              limit;
  } dstage_t;

endpackage

@@ hw/rtl/tpcs_in_if.sv @@
// ----------------------------------------------------------------------------
// tpcs_in_if
// Request channel: conversion kind and operand.
// ----------------------------------------------------------------------------
interface tpcs_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  tpcs_pkg::word_t      operand;

  modport source (output valid, output kind, output operand, input ready);
  modport sink   (input valid, input kind, input operand, output ready);
endinterface

@@ hw/rtl/tpcs_out_if.sv @@
// ----------------------------------------------------------------------------
// tpcs_out_if
// Result channel: converted word and fault flag.
// ----------------------------------------------------------------------------
interface tpcs_out_if;
  logic                 valid;
  logic                 ready;
  tpcs_pkg::word_t      converted;
  logic                 fault;

  modport source (output valid, output converted, output fault, input ready);
  modport sink   (input valid, input converted, input fault, output ready);
endinterface

@@ hw/rtl/two_point_code_scaler_unit.sv @@
// ----------------------------------------------------------------------------
// two_point_code_scaler_unit
// Two-point linear calibration between converter codes and physical values.
//
//   channel   dir  payload                 handshake
//   in_beat   in   kind, operand           valid / ready
//   out_beat  out  converted, fault        valid / ready
//   cfg_*     in   index (2b), data (16b)  write enable
//
// One beat per cycle unless the sequencer is busy or the output stalls;
// 4 numerator stages, 16 divider stages, output register. After reset and
// each register write a coefficient sequencer (64-step divide, 16-step
// multiply) runs with in_beat.ready low. An output stall freezes the pipeline.
// ----------------------------------------------------------------------------
module two_point_code_scaler_unit #(
  parameter int VALUE_MAX = 40000,
  parameter int CODE_MAX  = 4095
) (
  input  logic             clk,
  input  logic             rst_n,
  tpcs_in_if.sink          in_beat,
  tpcs_out_if.source       out_beat,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  tpcs_pkg::word_t  cfg_data
);

  logic              busy, en, accept;
  tpcs_pkg::coef_t   coef;
  tpcs_pkg::dstage_t front_out, div_out;
  logic              out_valid_r;
  tpcs_pkg::word_t   conv_r, conv_nxt;
  logic              fault_r;

  // Hold everything while a result waits
  assign en     = !out_valid_r || out_beat.ready;
  assign accept = in_beat.valid && in_beat.ready;
  assign in_beat.ready = en && !busy;

  tpcs_coef #(.VALUE_MAX(VALUE_MAX)) u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .coef      (coef)
  );

  tpcs_front #(.VALUE_MAX(VALUE_MAX), .CODE_MAX(CODE_MAX)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (accept),
    .in_kind    (in_beat.kind),
    .in_operand (in_beat.operand),
    .coef       (coef),
    .dout       (front_out)
  );

  tpcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (front_out),
    .dout  (div_out)
  );

  // Clamp and zero the quotient
  always_comb begin
    if (div_out.zero) begin
      conv_nxt = '0;
    end else if (div_out.clamp || (div_out.quo > div_out.limit)) begin
      conv_nxt = div_out.limit;
    end else begin
      conv_nxt = div_out.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      conv_r  <= conv_nxt;
      fault_r <= div_out.fault;
    end
  end

  assign out_beat.valid     = out_valid_r;
  assign out_beat.converted = conv_r;
  assign out_beat.fault     = fault_r;

endmodule

@@ hw/rtl/tpcs_coef.sv @@
// ----------------------------------------------------------------------------
// tpcs_coef
// Calibration registers and the sequencer that forms slope and offset:
// a 64-bit restoring divide followed by a 16-bit shift-add multiply.
// ----------------------------------------------------------------------------
module tpcs_coef #(
  parameter int VALUE_MAX = 40000
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  tpcs_pkg::word_t        cfg_data,
  output logic                   busy,
  output tpcs_pkg::coef_t        coef
);

  localparam logic [tpcs_pkg::SCALE_W-1:0] SCALE =
    tpcs_pkg::SCALE_W'((64'd1 << tpcs_pkg::SCALE_SHIFT) / VALUE_MAX);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  tpcs_pkg::word_t p1v_r, p1c_r, p2v_r, p2c_r;
  logic [2:0]      phase_r, phase_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [tpcs_pkg::SLOPE_W-1:0] num_r, num_nxt;
  tpcs_pkg::word_t dc_r, dc_nxt;
  tpcs_pkg::word_t rem_r, rem_nxt;
  logic [tpcs_pkg::NUM_W-1:0] acc_r, acc_nxt;
  logic [tpcs_pkg::NUM_W-1:0] mcand_r, mcand_nxt;
  tpcs_pkg::word_t mplier_r, mplier_nxt;
  tpcs_pkg::coef_t coef_r, coef_nxt;

  tpcs_pkg::word_t dp, dc;
  logic [tpcs_pkg::WORD_W:0] rem2;
  logic                      ge;

  // Write the calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= '0;
      p1c_r <= '0;
      p2v_r <= '0;
      p2c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpcs_pkg::REG_P1_VALUE: p1v_r <= cfg_data;
        tpcs_pkg::REG_P1_CODE:  p1c_r <= cfg_data;
        tpcs_pkg::REG_P2_VALUE: p2v_r <= cfg_data;
        tpcs_pkg::REG_P2_CODE:  p2c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence the coefficient computation
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    num_nxt    = num_r;
    dc_nxt     = dc_r;
    rem_nxt    = rem_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    coef_nxt   = coef_r;
    dp   = p2v_r - p1v_r;
    dc   = p2c_r - p1c_r;
    rem2 = {rem_r, num_r[tpcs_pkg::SLOPE_W-1]};
    ge   = (rem2 >= {1'b0, dc_r});
    case (phase_r)
      ST_START: begin
        num_nxt = tpcs_pkg::SLOPE_W'(SCALE) * tpcs_pkg::SLOPE_W'(dp)
                + tpcs_pkg::SLOPE_W'(dc >> 1);
        dc_nxt  = dc;
        rem_nxt = '0;
        acc_nxt = '0 - (tpcs_pkg::NUM_W'(SCALE) * tpcs_pkg::NUM_W'(p1v_r));
        cnt_nxt = '0;
        phase_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one quotient bit per cycle
        rem_nxt = ge ? tpcs_pkg::WORD_W'(rem2 - {1'b0, dc_r})
                     : rem2[tpcs_pkg::WORD_W-1:0];
        num_nxt = {num_r[tpcs_pkg::SLOPE_W-2:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(tpcs_pkg::SLOPE_W - 1)) begin
          cnt_nxt    = '0;
          mcand_nxt  = tpcs_pkg::NUM_W'(num_nxt);
          mplier_nxt = p1c_r;
          phase_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        // accumulate slope * point1_code
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == 6'(tpcs_pkg::WORD_W - 1)) begin
          phase_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        coef_nxt.dc_zero    = (dc_r == '0);
        coef_nxt.slope_zero = (num_r == '0);
        coef_nxt.slope      = num_r;
        coef_nxt.add0       = tpcs_pkg::NUM_W'(SCALE >> 1) - acc_r;
        coef_nxt.add1       = acc_r + tpcs_pkg::NUM_W'(num_r >> 1);
        phase_nxt           = ST_IDLE;
      end
      default: ;
    endcase
    if (cfg_we) begin
      phase_nxt = ST_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ST_START;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r    <= num_nxt;
    dc_r     <= dc_nxt;
    rem_r    <= rem_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    coef_r   <= coef_nxt;
  end

  assign busy = (phase_r != ST_IDLE);
  assign coef = coef_r;

endmodule

@@ hw/rtl/tpcs_front.sv @@
// ----------------------------------------------------------------------------
// tpcs_front
// Numerator pipeline: split multiply, partial sum, addend, range check.
// ----------------------------------------------------------------------------
module tpcs_front #(
  parameter int VALUE_MAX = 40000,
  parameter int CODE_MAX  = 4095
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic              in_kind,
  input  tpcs_pkg::word_t   in_operand,
  input  tpcs_pkg::coef_t   coef,
  output tpcs_pkg::dstage_t dout
);

  localparam logic [tpcs_pkg::SCALE_W-1:0] SCALE =
    tpcs_pkg::SCALE_W'((64'd1 << tpcs_pkg::SCALE_SHIFT) / VALUE_MAX);
  localparam int PP_W = 48;

  // stage A
  logic a_valid_r, a_fault_r;
  logic [PP_W-1:0] a_pl_r, a_ph_r;
  logic [tpcs_pkg::NUM_W-1:0]   a_add_r;
  logic [tpcs_pkg::SLOPE_W-1:0] a_div_r;
  tpcs_pkg::word_t a_lim_r;
  // stage B
  logic b_valid_r, b_fault_r;
  logic [tpcs_pkg::NUM_W-1:0]   b_prod_r, b_add_r;
  logic [tpcs_pkg::SLOPE_W-1:0] b_div_r;
  tpcs_pkg::word_t b_lim_r;
  // stage C
  logic c_valid_r, c_fault_r;
  logic [tpcs_pkg::NUM_W-1:0]   c_n_r;
  logic [tpcs_pkg::SLOPE_W-1:0] c_div_r;
  tpcs_pkg::word_t c_lim_r;
  // stage D
  tpcs_pkg::dstage_t d_r, d_nxt;

  logic [tpcs_pkg::SLOPE_W-1:0] mult;
  logic neg;

  assign mult = in_kind ? tpcs_pkg::SLOPE_W'(SCALE) : coef.slope;
  assign neg  = c_n_r[tpcs_pkg::NUM_W-1];

  always_comb begin
    d_nxt       = d_r;
    d_nxt.valid = c_valid_r;
    d_nxt.fault = c_fault_r;
    d_nxt.zero  = c_fault_r | neg;
    d_nxt.clamp = !neg && (c_n_r >= {2'b00, c_div_r, 16'h0000});
    d_nxt.div   = c_div_r;
    d_nxt.rem   = c_n_r;
    d_nxt.quo   = '0;
    d_nxt.limit = c_lim_r;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_r.valid <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_r.valid <= d_nxt.valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_fault_r <= coef.dc_zero | (in_kind & coef.slope_zero);
      a_pl_r    <= PP_W'(mult[31:0]) * PP_W'(in_operand);
      a_ph_r    <= PP_W'(mult[63:32]) * PP_W'(in_operand);
      a_add_r   <= in_kind ? coef.add1 : coef.add0;
      a_div_r   <= in_kind ? coef.slope : tpcs_pkg::SLOPE_W'(SCALE);
      a_lim_r   <= in_kind ? tpcs_pkg::WORD_W'(CODE_MAX) : tpcs_pkg::WORD_W'(VALUE_MAX);
      b_fault_r <= a_fault_r;
      b_prod_r  <= tpcs_pkg::NUM_W'(a_pl_r) + (tpcs_pkg::NUM_W'(a_ph_r) << 32);
      b_add_r   <= a_add_r;
      b_div_r   <= a_div_r;
      b_lim_r   <= a_lim_r;
      c_fault_r <= b_fault_r;
      c_n_r     <= b_prod_r + b_add_r;
      c_div_r   <= b_div_r;
      c_lim_r   <= b_lim_r;
      d_r.fault <= d_nxt.fault;
      d_r.zero  <= d_nxt.zero;
      d_r.clamp <= d_nxt.clamp;
      d_r.div   <= d_nxt.div;
      d_r.rem   <= d_nxt.rem;
      d_r.quo   <= d_nxt.quo;
      d_r.limit <= d_nxt.limit;
    end
  end

  assign dout = d_r;

endmodule

@@ hw/rtl/tpcs_div.sv @@
// ----------------------------------------------------------------------------
// tpcs_div
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module tpcs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tpcs_pkg::dstage_t din,
  output tpcs_pkg::dstage_t dout
);

  tpcs_pkg::dstage_t st_r  [tpcs_pkg::QUO_W+1];
  tpcs_pkg::dstage_t st_nxt[tpcs_pkg::QUO_W];

  assign st_r[0] = din;

  for (genvar i = 0; i < tpcs_pkg::QUO_W; i++) begin : g_stage
    localparam int B = tpcs_pkg::QUO_W - 1 - i;
    logic [tpcs_pkg::NUM_W-1:0] sh;
    logic                       ge;

    assign sh = tpcs_pkg::NUM_W'(st_r[i].div) << B;
    assign ge = (st_r[i].rem >= sh);

    // Try one subtract
    always_comb begin
      st_nxt[i]        = st_r[i];
      st_nxt[i].rem    = ge ? st_r[i].rem - sh : st_r[i].rem;
      st_nxt[i].quo[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i+1].valid <= 1'b0;
      end else if (en) begin
        st_r[i+1].valid <= st_nxt[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1].fault <= st_nxt[i].fault;
        st_r[i+1].zero  <= st_nxt[i].zero;
        st_r[i+1].clamp <= st_nxt[i].clamp;
        st_r[i+1].div   <= st_nxt[i].div;
        st_r[i+1].rem   <= st_nxt[i].rem;
        st_r[i+1].quo   <= st_nxt[i].quo;
        st_r[i+1].limit <= st_nxt[i].limit;
      end
    end
  end

  assign dout = st_r[tpcs_pkg::QUO_W];

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-point code scaler. A driver sends request
// beats from a queue, a monitor checks each result beat against a 128-bit
// calibration predictor kept in step with the register writes. Register
// writes happen only while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb;

  localparam int VALUE_MAX  = 40000;
  localparam int CODE_MAX   = 4095;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_WAIT = 30;

  // conversion kinds
  localparam logic KIND_TO_VALUE = 1'b0;
  localparam logic KIND_TO_CODE  = 1'b1;

  typedef struct {
    logic            kind;
    tpcs_pkg::word_t operand;
  } request_t;

  typedef struct {
    tpcs_pkg::word_t converted;
    logic            fault;
  } conversion_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  tpcs_pkg::word_t cfg_data;

  tpcs_in_if  req_ch ();
  tpcs_out_if res_ch ();

  two_point_code_scaler_unit #(
    .VALUE_MAX(VALUE_MAX),
    .CODE_MAX (CODE_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (req_ch),
    .out_beat (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // calibration points as the block holds them
  tpcs_pkg::word_t cal_p1_value, cal_p1_code, cal_p2_value, cal_p2_code;

  request_t    pending_q[$];
  conversion_t awaited_q[$];
  int errors;
  int cycles;
  bit send_idle, recv_idle, send_hold;
  int send_gap, recv_gap;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // compute one conversion at full width from the current calibration
  function automatic conversion_t calibrate(input logic kind,
                                            input tpcs_pkg::word_t operand);
    logic signed [127:0] scale, dp, dc, slope, offs, num, div, lim, quo;
    logic signed [127:0] p1v, p1c, opv;
    tpcs_pkg::word_t dpw, dcw;
    conversion_t r;
    r.converted = '0;
    r.fault     = 1'b0;
    scale = (128'sd1 <<< tpcs_pkg::SCALE_SHIFT) / VALUE_MAX;
    dpw = cal_p2_value - cal_p1_value;
    dcw = cal_p2_code - cal_p1_code;
    dp  = {112'd0, dpw};
    dc  = {112'd0, dcw};
    p1v = {112'd0, cal_p1_value};
    p1c = {112'd0, cal_p1_code};
    opv = {112'd0, operand};
    if (dc == 0) begin
      r.fault = 1'b1;
      return r;
    end
    slope = (scale * dp + dc / 2) / dc;
    offs  = slope * p1c - scale * p1v;
    if (kind == KIND_TO_VALUE) begin
      num = slope * opv - offs + scale / 2;
      div = scale;
      lim = VALUE_MAX;
    end else begin
      if (slope == 0) begin
        r.fault = 1'b1;
        return r;
      end
      num = scale * opv + offs + slope / 2;
      div = slope;
      lim = CODE_MAX;
    end
    if (num < 0) return r;
    quo = num / div;
    if (quo > lim) quo = lim;
    r.converted = quo[15:0];
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // driver: present request beats, predict at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_gap     <= 0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold the beat
    end else begin
      if (req_ch.valid && req_ch.ready)
        awaited_q.push_back(calibrate(req_ch.kind, req_ch.operand));
      if (send_gap > 0) begin
        send_gap     <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0 && !send_hold) begin
        req_ch.kind    <= pending_q[0].kind;
        req_ch.operand <= pending_q[0].operand;
        req_ch.valid   <= 1'b1;
        void'(pending_q.pop_front());
        send_gap <= send_idle ? $urandom_range(0, 11) : 0;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: stall the result side and check each beat
  always @(posedge clk) begin
    conversion_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_q.size() == 0) begin
          report($sformatf("unexpected result %0d fault %0b",
                           res_ch.converted, res_ch.fault));
        end else begin
          want = awaited_q.pop_front();
          if (res_ch.converted !== want.converted)
            report($sformatf("converted %0d, want %0d", res_ch.converted,
                             want.converted));
          if (res_ch.fault !== want.fault)
            report($sformatf("fault %0b, want %0b", res_ch.fault, want.fault));
        end
        recv_gap <= recv_idle ? $urandom_range(0, 11) : 0;
        res_ch.ready <= !recv_idle;
      end else if (recv_gap > 0) begin
        recv_gap     <= recv_gap - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || req_ch.valid || awaited_q.size() > 0)
      @(posedge clk);
  endtask

  // write all four points while the pipeline is empty
  task automatic load_points(input tpcs_pkg::word_t p1v, input tpcs_pkg::word_t p1c,
                             input tpcs_pkg::word_t p2v, input tpcs_pkg::word_t p2c);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= tpcs_pkg::REG_P1_VALUE; cfg_data <= p1v;
    @(posedge clk); cfg_index <= tpcs_pkg::REG_P1_CODE;  cfg_data <= p1c;
    @(posedge clk); cfg_index <= tpcs_pkg::REG_P2_VALUE; cfg_data <= p2v;
    @(posedge clk); cfg_index <= tpcs_pkg::REG_P2_CODE;  cfg_data <= p2c;
    @(posedge clk); cfg_we <= 1'b0;
    cal_p1_value = p1v;
    cal_p1_code  = p1c;
    cal_p2_value = p2v;
    cal_p2_code  = p2c;
  endtask

  task automatic queue_random(input int n);
    request_t it;
    repeat (n) begin
      it.kind = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: it.operand = 16'($urandom_range(0, 65535));
        1: it.operand = 16'($urandom_range(0, CODE_MAX));
        2: it.operand = 16'($urandom_range(0, VALUE_MAX));
        default: it.operand = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
      pending_q.push_back(it);
    end
  endtask

  task automatic queue_edges();
    tpcs_pkg::word_t ops[6];
    ops = '{16'h0000, 16'h0001, 16'(CODE_MAX), 16'(VALUE_MAX), 16'h8000, 16'hFFFF};
    foreach (ops[i]) begin
      pending_q.push_back('{KIND_TO_VALUE, ops[i]});
      pending_q.push_back('{KIND_TO_CODE, ops[i]});
    end
  endtask

  // stimulus
  initial begin
    tpcs_pkg::word_t a, b, c, d;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = tpcs_pkg::REG_P1_VALUE;
    cfg_data  = '0;
    req_ch.valid   = 1'b0;
    req_ch.kind    = KIND_TO_VALUE;
    req_ch.operand = '0;
    res_ch.ready   = 1'b0;
    errors = 0;
    cycles = 0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_hold = 1'b0;
    cal_p1_value = '0;
    cal_p1_code  = '0;
    cal_p2_value = '0;
    cal_p2_code  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // equal codes after reset: every request faults
    pending_q.push_back('{KIND_TO_VALUE, 16'h0000});
    pending_q.push_back('{KIND_TO_CODE, 16'hFFFF});
    pending_q.push_back('{KIND_TO_VALUE, 16'hFFFF});
    pending_q.push_back('{KIND_TO_CODE, 16'h0000});

    // nominal calibration, edges of the operand range
    load_points(16'd0, 16'd0, 16'(VALUE_MAX), 16'(CODE_MAX));
    queue_edges();
    // flat slope: value to code faults
    load_points(16'd1000, 16'd10, 16'd1000, 16'd3000);
    queue_edges();
    // register extremes: steepest and wrapped differences
    load_points(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    queue_random(30);
    load_points(16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
    queue_random(30);
    // inverted slope
    load_points(16'(VALUE_MAX), 16'd0, 16'd0, 16'(CODE_MAX));
    queue_random(40);

    // random calibrations, idling switched per phase
    for (int ph = 0; ph < 8; ph++) begin
      a = 16'($urandom_range(0, VALUE_MAX));
      b = 16'($urandom_range(0, CODE_MAX));
      c = 16'($urandom_range(0, VALUE_MAX));
      d = 16'($urandom_range(0, CODE_MAX));
      if (ph % 3 == 2) begin
        a = 16'($urandom_range(0, 65535));
        b = 16'($urandom_range(0, 65535));
        c = 16'($urandom_range(0, 65535));
        d = 16'($urandom_range(0, 65535));
      end
      if (ph == 5) d = b;
      load_points(a, b, c, d);
      send_idle = ph % 4 != 0;
      recv_idle = ph % 4 != 1;
      queue_random(50);
      // pause the sender until everything has come back
      while (pending_q.size() > 0 || req_ch.valid) @(posedge clk);
      send_hold = 1'b1;
      while (awaited_q.size() > 0) @(posedge clk);
      send_hold = 1'b0;
      queue_random(50);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tpcs_pkg.sv
hw/rtl/tpcs_in_if.sv
hw/rtl/tpcs_out_if.sv
hw/rtl/tpcs_coef.sv
hw/rtl/tpcs_front.sv
hw/rtl/tpcs_div.sv
hw/rtl/two_point_code_scaler_unit.sv
verif/tb.sv
